[sv/fixed_point_alu_defines.svh]
// assertion macros shared by the alu rtl
`ifndef FIXED_POINT_ALU_DEFINES_SVH
`define FIXED_POINT_ALU_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define FPA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fixed point alu check failed");

// condition holds in the cycle after the trigger
`define FPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fixed point alu check failed");

`endif

[sv/fpa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;
    // internal value width, wide enough for any product or shifted operand
    localparam int IW = 66;

    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_DIV  = 4'd3;
    localparam logic [3:0] OP_GT   = 4'd4;
    localparam logic [3:0] OP_LT   = 4'd5;
    localparam logic [3:0] OP_GE   = 4'd6;
    localparam logic [3:0] OP_LE   = 4'd7;
    localparam logic [3:0] OP_EQ   = 4'd8;
    localparam logic [3:0] OP_NE   = 4'd9;
    localparam logic [3:0] OP_INC  = 4'd10;
    localparam logic [3:0] OP_DEC  = 4'd11;
    localparam logic [3:0] OP_MIN  = 4'd12;
    localparam logic [3:0] OP_MAX  = 4'd13;
    localparam logic [3:0] OP_FINT = 4'd14;
    localparam logic [3:0] OP_TINT = 4'd15;

    // per-item control and partial result carried down the pipe
    typedef struct packed {
        logic [3:0]           op;
        logic signed [IW-1:0] v;
        logic                 cmp;
        logic                 dbz;
        logic                 neg;
    } t_meta;
endpackage
`default_nettype wire

[sv/fixed_point_alu.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_point_alu_defines.svh"
// Signed fixed-point ALU (FRACTION_BITS fraction bits, saturating to WORD_BITS).
// Takes one word per cycle while the output is not stalled and returns results in
// order. Every word, whatever its opcode, passes the same stages: one input stage, one
// multiply-round stage, a restoring divider that resolves one quotient bit per
// stage over 32 + FRACTION_BITS stages, a rounding stage and a saturating output
// register. Multiply and divide round half away from zero; divide by zero
// returns the saturated sign of the dividend and sets divided_by_zero. A stall
// at the output holds the whole pipe.
module fixed_point_alu #(
    parameter int FRACTION_BITS = 8,
    parameter int WORD_BITS     = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // opcode[3:0], operand_a[35:4], operand_b[67:36], zero pad
    input  wire logic [71:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // result_value[31:0], compare_true[32], overflowed[33], divided_by_zero[34], pad
    output logic [39:0]      o_m_axis_tdata
);
    import fpa_pkg::*;

    localparam int NB = 32 + FRACTION_BITS;
    localparam logic signed [IW-1:0] WMAX = IW'((IW'(1) << (WORD_BITS - 1)) - IW'(1));
    localparam logic signed [IW-1:0] WMIN = -WMAX - IW'(1);

    logic en;
    logic [NB+2:0] r_vld;
    t_meta r_meta [0:NB+2];
    logic [31:0] r_rem [0:NB];
    logic [NB-1:0] r_nq [0:NB];
    logic [31:0] r_d [0:NB];
    logic signed [63:0] r_prod;
    logic [31:0] r_num;
    logic [31:0] r_dsr;
    logic r_out_vld;
    logic signed [31:0] r_out_val;
    logic r_out_cmp, r_out_ovf, r_out_dbz;

    // whole pipe moves when the output register is free
    assign en = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[NB+1:0], i_s_axis_tvalid};
            r_out_vld <= r_vld[NB+2];
        end
    end

    // stage 1: simple operations, product, divider operands
    logic [3:0] in_op;
    logic signed [31:0] in_a, in_b;
    logic signed [IW-1:0] a_x, b_x;
    t_meta n_m1;
    assign in_op = i_s_axis_tdata[3:0];
    assign in_a  = i_s_axis_tdata[35:4];
    assign in_b  = i_s_axis_tdata[67:36];
    assign a_x   = IW'(in_a);
    assign b_x   = IW'(in_b);

    always_comb begin
        n_m1     = '0;
        n_m1.op  = in_op;
        n_m1.neg = in_a[31] ^ in_b[31];
        unique case (in_op)
            OP_ADD:  n_m1.v = a_x + b_x;
            OP_SUB:  n_m1.v = a_x - b_x;
            OP_MUL:  n_m1.v = '0;
            OP_DIV: begin
                if (in_b == 32'sd0) begin
                    n_m1.dbz = 1'b1;
                    if (in_a > 32'sd0) n_m1.v = WMAX;
                    else if (in_a < 32'sd0) n_m1.v = WMIN;
                    else n_m1.v = '0;
                end
            end
            OP_GT:   n_m1.cmp = in_a > in_b;
            OP_LT:   n_m1.cmp = in_a < in_b;
            OP_GE:   n_m1.cmp = in_a >= in_b;
            OP_LE:   n_m1.cmp = in_a <= in_b;
            OP_EQ:   n_m1.cmp = in_a == in_b;
            OP_NE:   n_m1.cmp = in_a != in_b;
            OP_INC:  n_m1.v = a_x + IW'(1);
            OP_DEC:  n_m1.v = a_x - IW'(1);
            OP_MIN:  n_m1.v = (in_a < in_b) ? a_x : b_x;
            OP_MAX:  n_m1.v = (in_a > in_b) ? a_x : b_x;
            OP_FINT: n_m1.v = a_x <<< FRACTION_BITS;
            OP_TINT: n_m1.v = a_x >>> FRACTION_BITS;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_meta[0] <= n_m1;
            r_prod    <= in_a * in_b;
            r_num     <= in_a[31] ? 32'(-in_a) : 32'(in_a);
            r_dsr     <= in_b[31] ? 32'(-in_b) : 32'(in_b);
        end
    end

    // stage 2: round the product, load the divider
    logic [63:0] prod_mag, prod_rnd;
    t_meta n_m2;
    assign prod_mag = r_prod[63] ? 64'(-r_prod) : 64'(r_prod);
    assign prod_rnd = (prod_mag + (64'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;

    always_comb begin
        n_m2 = r_meta[0];
        if (r_meta[0].op == OP_MUL) begin
            n_m2.v = r_prod[63] ? -IW'(prod_rnd) : IW'(prod_rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_meta[1] <= n_m2;
            r_rem[0]  <= '0;
            r_nq[0]   <= {r_num, FRACTION_BITS'(0)};
            r_d[0]    <= r_dsr;
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar j = 0; j < NB; j++) begin : g_div
        logic [32:0] trial;
        logic        take;
        assign trial = {r_rem[j], r_nq[j][NB-1]};
        assign take  = trial >= {1'b0, r_d[j]};
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem[j+1]  <= take ? 32'(trial - {1'b0, r_d[j]}) : trial[31:0];
                r_nq[j+1]   <= {r_nq[j][NB-2:0], take};
                r_d[j+1]    <= r_d[j];
                r_meta[j+2] <= r_meta[j+1];
            end
        end
    end

    // round the quotient half away from zero and apply the sign
    logic        q_up;
    logic [NB:0] q_rnd;
    t_meta       n_mr;
    assign q_up  = {r_rem[NB], 1'b0} >= {1'b0, r_d[NB]};
    assign q_rnd = {1'b0, r_nq[NB]} + (NB + 1)'(q_up);

    always_comb begin
        n_mr = r_meta[NB+1];
        if (r_meta[NB+1].op == OP_DIV && !r_meta[NB+1].dbz) begin
            n_mr.v = r_meta[NB+1].neg ? -IW'(q_rnd) : IW'(q_rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_meta[NB+2] <= n_mr;
        end
    end

    // saturate to the word range into the output register
    t_meta last_m;
    logic signed [IW-1:0] n_val;
    logic n_ovf;
    assign last_m = r_meta[NB+2];

    always_comb begin
        n_val = last_m.v;
        n_ovf = 1'b0;
        if (!last_m.dbz) begin
            if (last_m.v > WMAX) begin
                n_val = WMAX;
                n_ovf = 1'b1;
            end else if (last_m.v < WMIN) begin
                n_val = WMIN;
                n_ovf = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_val <= n_val[31:0];
            r_out_cmp <= last_m.cmp;
            r_out_ovf <= n_ovf;
            r_out_dbz <= last_m.dbz;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {5'd0, r_out_dbz, r_out_ovf, r_out_cmp, r_out_val};

    // checks
    `FPA_ASSERT_NOW(a_dbz_no_ovf, r_out_vld && r_out_dbz, !r_out_ovf)
    `FPA_ASSERT_NOW(a_cmp_zero, r_out_vld && r_out_cmp, r_out_val == 32'sd0 && !r_out_ovf)
    `FPA_ASSERT_NEXT(a_stall_holds, !en, r_vld == $past(r_vld) && r_out_vld)
    `FPA_ASSERT_NEXT(a_accept_enters, i_s_axis_tvalid && en, r_vld[0])
endmodule
`default_nettype wire

[tb/sv/fixed_point_alu_test.sv]
`timescale 1ns / 1ps
module fixed_point_alu_test;
    import fpa_pkg::*;

    localparam int FRAC = 8;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic [31:0] value;
        logic        cmp_true;
        logic        ovf;
        logic        dbz;
    } t_alu_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // opcode[3:0], operand_a[35:4], operand_b[67:36], zero pad
    logic [71:0] i_s_axis_tdata = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // result_value[31:0], compare_true[32], overflowed[33], divided_by_zero[34], pad
    logic [39:0] o_m_axis_tdata;

    logic [71:0]  pending_words[$];
    t_alu_result  expected_results[$];
    int           error_count = 0;
    int           results_seen = 0;
    int           cycle_count = 0;
    int           burst_left = 0;
    int           gap_left = 0;
    int           stall_phase = 0;
    bit           stim_done = 1'b0;
    int           op_hits[16];

    fixed_point_alu i_dut (.*);

    always #2 i_clk = ~i_clk;

    // saturate a wide value to 32-bit signed range
    function automatic longint clamp32(input longint v, inout logic ovf);
        if (v > 64'sd2147483647) begin
            ovf = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            ovf = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // exact fixed-point result of one word
    function automatic t_alu_result alu_predict(input logic [3:0] op,
                                                input logic [31:0] ra,
                                                input logic [31:0] rb);
        longint a, b, v, p;
        longint unsigned m, n, d, q, r;
        t_alu_result res;
        a = longint'($signed(ra));
        b = longint'($signed(rb));
        v = 0;
        res = '0;
        case (op)
            OP_ADD:  v = a + b;
            OP_SUB:  v = a - b;
            OP_MUL: begin
                p = a * b;
                m = (p < 0) ? -p : p;
                m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
                v = (p < 0) ? -longint'(m) : longint'(m);
            end
            OP_DIV: begin
                if (b == 0) begin
                    res.dbz = 1'b1;
                    v = (a > 0) ? 2147483647 : ((a < 0) ? -64'sd2147483648 : 0);
                end else begin
                    n = ((a < 0) ? -a : a) << FRAC;
                    d = (b < 0) ? -b : b;
                    q = n / d;
                    r = n % d;
                    if (2 * r >= d) q++;
                    v = ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
                end
            end
            OP_GT:   res.cmp_true = a > b;
            OP_LT:   res.cmp_true = a < b;
            OP_GE:   res.cmp_true = a >= b;
            OP_LE:   res.cmp_true = a <= b;
            OP_EQ:   res.cmp_true = a == b;
            OP_NE:   res.cmp_true = a != b;
            OP_INC:  v = a + 1;
            OP_DEC:  v = a - 1;
            OP_MIN:  v = (a < b) ? a : b;
            OP_MAX:  v = (a > b) ? a : b;
            OP_FINT: v = a * (64'sd1 << FRAC);
            default: v = a >>> FRAC;
        endcase
        if (!res.dbz) v = clamp32(v, res.ovf);
        res.value = v[31:0];
        return res;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'(int'($urandom_range(0, 8)) - 4);
            3: return 32'(int'($urandom_range(0, 65535)) - 32768);
            4: return 32'(int'($urandom_range(0, 2000)) - 1000) << FRAC;
            5: return 32'h00000000;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_word(input logic [3:0] op, input logic [31:0] a,
                             input logic [31:0] b);
        pending_words.push_back({4'b0, b, a, op});
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("mismatch %s: got %h expected %h (result %0d)",
                 what, got, want, results_seen);
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_results.push_back(alu_predict(i_s_axis_tdata[3:0],
                    i_s_axis_tdata[35:4], i_s_axis_tdata[67:36]));
                op_hits[i_s_axis_tdata[3:0]]++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (gap_left > 0 || pending_words.size() == 0) begin
                    i_s_axis_tvalid <= 1'b0;
                    if (gap_left > 0) gap_left <= gap_left - 1;
                end else begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= pending_words.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // receiver: stall pattern alternating open stretches and choppy stretches
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            stall_phase <= (stall_phase + 1) % 200;
            if (stall_phase < 80) i_m_axis_tready <= 1'b1;
            else if (stall_phase < 140) i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            else i_m_axis_tready <= ($urandom_range(0, 2) == 0);
        end
    end

    // checker of accepted result words
    always @(posedge i_clk) begin
        t_alu_result want, got;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = {o_m_axis_tdata[31:0], o_m_axis_tdata[32], o_m_axis_tdata[33],
                   o_m_axis_tdata[34]};
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected word", o_m_axis_tdata[31:0], 32'h0);
            end else begin
                want = expected_results.pop_front();
                if (got.value !== want.value)
                    report_mismatch("result_value", got.value, want.value);
                if (got.cmp_true !== want.cmp_true)
                    report_mismatch("compare_true", 32'(got.cmp_true), 32'(want.cmp_true));
                if (got.ovf !== want.ovf)
                    report_mismatch("overflowed", 32'(got.ovf), 32'(want.ovf));
                if (got.dbz !== want.dbz)
                    report_mismatch("divided_by_zero", 32'(got.dbz), 32'(want.dbz));
            end
        end
    end

    // stimulus, end of run and timeout
    initial begin
        logic [3:0] op;
        int settle;
        // directed words: extremes, every opcode, rounding ties, divide by zero
        for (int k = 0; k < 16; k++) push_word(4'(k), 32'h7fffffff, 32'h80000000);
        push_word(OP_DIV, 32'h00000100, 32'h00000000);
        push_word(OP_DIV, 32'hffffff00, 32'h00000000);
        push_word(OP_DIV, 32'h00000000, 32'h00000000);
        push_word(OP_MUL, 32'h00000001, 32'h00000080);
        push_word(OP_MUL, 32'hffffffff, 32'h00000080);
        push_word(OP_DIV, 32'h00000001, 32'h00000200);
        push_word(OP_TINT, 32'hffffffff, 32'h0);
        push_word(OP_MIN, 32'h00000005, 32'h00000005);
        push_word(OP_MUL, 32'h80000000, 32'h80000000);
        for (int k = 0; k < 800; k++) begin
            op = 4'($urandom_range(0, 15));
            push_word(op, pick_operand(), pick_operand());
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_words.size() != 0 || i_s_axis_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
        settle = 0;
        while (settle < 100) begin
            @(posedge i_clk);
            settle++;
        end
        $display("checked %0d result words over all 16 opcodes, mul/div ties,", results_seen);
        $display("saturation, divide by zero and stalls on both sides");
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (cycle_count >= LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end
endmodule

[fixed_point_alu.f]
+incdir+sv
sv/fpa_pkg.sv
sv/fixed_point_alu.sv
tb/sv/fixed_point_alu_test.sv
